/* rtl/sps_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants for the servo pulse slew block
// Angle scaling constants, channel and beat-kind codes, state reset values.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned PULSE_W   = 12;
  localparam int unsigned ANGLE_W   = 13;
  localparam int unsigned DIFF_W    = 15;
  localparam int unsigned MUL_W     = 10;
  localparam int unsigned PROD_W    = PULSE_W + MUL_W;
  localparam int unsigned SCALE_SHIFT = 10;

  localparam logic [PULSE_W-1:0] PULSE_BASE = 12'd500;
  localparam logic [MUL_W-1:0]   SCALE_MUL  = 10'd711;

  // angle limits in Q8.4 degrees
  localparam logic signed [DIFF_W-1:0] DEG0_Q4   = 15'sd0;
  localparam logic signed [DIFF_W-1:0] DEG20_Q4  = 15'sd320;
  localparam logic signed [DIFF_W-1:0] DEG90_Q4  = 15'sd1440;
  localparam logic signed [DIFF_W-1:0] DEG160_Q4 = 15'sd2560;
  localparam logic signed [DIFF_W-1:0] DEG180_Q4 = 15'sd2880;

  // reset values of the pulse state
  localparam logic [PULSE_W-1:0] RST_TARGET_A  = 12'd2000;
  localparam logic [PULSE_W-1:0] RST_TARGET_B  = 12'd500;
  localparam logic [PULSE_W-1:0] RST_CURRENT_A = 12'd2500;
  localparam logic [PULSE_W-1:0] RST_CURRENT_B = 12'd500;
  localparam logic [PULSE_W-1:0] RST_CURRENT_C = 12'd1500;
  localparam logic [PULSE_W-1:0] RST_CURRENT_D = 12'd2270;

  typedef enum logic [1:0] {
    CH_A = 2'd0,
    CH_B = 2'd1,
    CH_C = 2'd2,
    CH_D = 2'd3
  } chan_t;

  typedef enum logic {
    KIND_ANGLE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  // update command from the beat register to the state registers
  typedef struct packed {
    logic  fire;
    kind_t kind;
    chan_t channel;
  } sps_cmd_t;

endpackage

/* rtl/sps_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_map: angle to pulse mapping
// Per-channel inversion and clamp, then pulse = 500 + (a_q4 * 711) >> 10.
// ----------------------------------------------------------------------------
module sps_map (
  input  sps_pkg::chan_t              channel,
  input  logic signed [12:0]          angle_q4,
  output logic [sps_pkg::PULSE_W-1:0] pulse
);
  import sps_pkg::*;

  logic signed [DIFF_W-1:0] ang_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] lo;
  logic signed [DIFF_W-1:0] hi;
  logic signed [DIFF_W-1:0] clamped;
  logic [PROD_W-1:0]        prod;

  assign ang_ext = DIFF_W'(angle_q4);

  always_comb begin
    case (channel)
      CH_A: begin
        diff = DEG180_Q4 - ang_ext;
        lo   = DEG20_Q4;
        hi   = DEG180_Q4;
      end
      CH_D: begin
        diff = DEG160_Q4 - ang_ext;
        lo   = DEG90_Q4;
        hi   = DEG160_Q4;
      end
      default: begin
        diff = ang_ext;
        lo   = DEG0_Q4;
        hi   = DEG180_Q4;
      end
    endcase
  end

  always_comb begin
    if (diff < lo) begin
      clamped = lo;
    end else if (diff > hi) begin
      clamped = hi;
    end else begin
      clamped = diff;
    end
  end

  // clamped lies in 0..2880, so the low 12 bits carry it exactly
  assign prod  = PROD_W'(clamped[PULSE_W-1:0]) * PROD_W'(SCALE_MUL);
  assign pulse = PULSE_BASE + PULSE_W'(prod >> SCALE_SHIFT);

endmodule

/* rtl/sps_servo_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_servo_state: target and current pulse registers
// Commands load targets (ch 0/1) or pulses (ch 2/3); ticks slew ch 0/1 by one.
// ----------------------------------------------------------------------------
module sps_servo_state (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sps_pkg::sps_cmd_t           cmd,
  input  logic [sps_pkg::PULSE_W-1:0] pulse,
  output logic [sps_pkg::PULSE_W-1:0] pulse_a,
  output logic [sps_pkg::PULSE_W-1:0] pulse_b,
  output logic [sps_pkg::PULSE_W-1:0] pulse_c,
  output logic [sps_pkg::PULSE_W-1:0] pulse_d
);
  import sps_pkg::*;

  logic [PULSE_W-1:0] target_a_r, target_a_nxt;
  logic [PULSE_W-1:0] target_b_r, target_b_nxt;
  logic [PULSE_W-1:0] current_a_r, current_a_nxt;
  logic [PULSE_W-1:0] current_b_r, current_b_nxt;
  logic [PULSE_W-1:0] current_c_r, current_c_nxt;
  logic [PULSE_W-1:0] current_d_r, current_d_nxt;

  function automatic logic [PULSE_W-1:0] slew_step(input logic [PULSE_W-1:0] cur,
                                                   input logic [PULSE_W-1:0] tgt);
    if (cur < tgt) begin
      return cur + 1'b1;
    end else if (cur > tgt) begin
      return cur - 1'b1;
    end
    return cur;
  endfunction

  always_comb begin
    target_a_nxt  = target_a_r;
    target_b_nxt  = target_b_r;
    current_a_nxt = current_a_r;
    current_b_nxt = current_b_r;
    current_c_nxt = current_c_r;
    current_d_nxt = current_d_r;
    if (cmd.fire) begin
      if (cmd.kind == KIND_TICK) begin
        current_a_nxt = slew_step(current_a_r, target_a_r);
        current_b_nxt = slew_step(current_b_r, target_b_r);
      end else begin
        case (cmd.channel)
          CH_A:    target_a_nxt  = pulse;
          CH_B:    target_b_nxt  = pulse;
          CH_C:    current_c_nxt = pulse;
          CH_D:    current_d_nxt = pulse;
          default: current_d_nxt = pulse;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_a_r  <= RST_TARGET_A;
      target_b_r  <= RST_TARGET_B;
      current_a_r <= RST_CURRENT_A;
      current_b_r <= RST_CURRENT_B;
      current_c_r <= RST_CURRENT_C;
      current_d_r <= RST_CURRENT_D;
    end else begin
      target_a_r  <= target_a_nxt;
      target_b_r  <= target_b_nxt;
      current_a_r <= current_a_nxt;
      current_b_r <= current_b_nxt;
      current_c_r <= current_c_nxt;
      current_d_r <= current_d_nxt;
    end
  end

  assign pulse_a = current_a_r;
  assign pulse_b = current_b_r;
  assign pulse_c = current_c_r;
  assign pulse_d = current_d_r;

endmodule

/* rtl/servo_angle_pulse_slew_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_angle_pulse_slew_top: four-channel servo pulse generator with slew
// Maps angle commands to timer compare values and ramps channels 0 and 1.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one beat is either an angle command (in_tuser = 0)
//   for the channel in in_tdata[1:0], angle Q8.4 signed in in_tdata[14:2],
//   or a ramp tick (in_tuser = 1) whose tdata is ignored.
//   Output stream (out_*): every input beat yields exactly one output beat
//   with all four compare values as they stand after that beat.
//   Path: from input accept to out_tvalid a beat passes the input register,
//   then the state/result register. Throughput: one beat per cycle while
//   out_tready stays high; the mapping multiplier between the two registers
//   only sets the clock period.
//   The four pulse state registers double as the output register: they only
//   change when a beat moves into an empty or draining output slot.
//   Stall: while out_tready is low the output beat holds; one more input beat
//   is taken into the input register, after which in_tready drops.
//   Reset (rst_n low, synchronous): both slots empty, pulses return to
//   2500/500/1500/2270 with targets 2000/500.
// ----------------------------------------------------------------------------
module servo_angle_pulse_slew_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [1:0] channel, [14:2] angle_q4, [15] zero
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [11:0] pulse_a, [23:12] pulse_b,
                                  // [35:24] pulse_c, [47:36] pulse_d
);
  import sps_pkg::*;

  // input beat register
  logic               in_v_r;
  kind_t              kind_r;
  chan_t              chan_r;
  logic signed [12:0] angle_r;

  logic               out_v_r;
  logic               move;
  logic [PULSE_W-1:0] pulse;
  sps_cmd_t           cmd;
  logic [PULSE_W-1:0] pulse_a, pulse_b, pulse_c, pulse_d;

  // beat advances into the state/output slot when that slot is free or draining
  assign move      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r  <= kind_t'(in_tuser);
      chan_r  <= chan_t'(in_tdata[1:0]);
      angle_r <= in_tdata[14:2];
    end
  end

  sps_map u_map (
    .channel  (chan_r),
    .angle_q4 (angle_r),
    .pulse    (pulse)
  );

  assign cmd.fire    = move;
  assign cmd.kind    = kind_r;
  assign cmd.channel = chan_r;

  sps_servo_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .pulse   (pulse),
    .pulse_a (pulse_a),
    .pulse_b (pulse_b),
    .pulse_c (pulse_c),
    .pulse_d (pulse_d)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {pulse_d, pulse_c, pulse_b, pulse_a};

endmodule

/* rtl/sps_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_chk: port-level checks for the servo pulse slew block
// Output hold on stall, pulse ranges, one-count ramp steps, quiet idle.
// ----------------------------------------------------------------------------
module sps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output beat changed under stall");

  // mapped pulses stay within 500..2500
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:0] >= 12'd500 && out_tdata[11:0] <= 12'd2500 &&
                    out_tdata[23:12] >= 12'd500 && out_tdata[23:12] <= 12'd2500 &&
                    out_tdata[35:24] >= 12'd500 && out_tdata[35:24] <= 12'd2499 &&
                    out_tdata[47:36] >= 12'd500 && out_tdata[47:36] <= 12'd2499))
    else $error("pulse out of range");

  // ramped channels move by at most one count per cycle
  a_ramp_a: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ({1'b0, out_tdata[11:0]} == {1'b0, $past(out_tdata[11:0])} ||
                      {1'b0, out_tdata[11:0]} == {1'b0, $past(out_tdata[11:0])} + 13'd1 ||
                      {1'b0, out_tdata[11:0]} + 13'd1 == {1'b0, $past(out_tdata[11:0])}))
    else $error("channel 0 jumped");

  a_ramp_b: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ({1'b0, out_tdata[23:12]} == {1'b0, $past(out_tdata[23:12])} ||
                      {1'b0, out_tdata[23:12]} == {1'b0, $past(out_tdata[23:12])} + 13'd1 ||
                      {1'b0, out_tdata[23:12]} + 13'd1 == {1'b0, $past(out_tdata[23:12])}))
    else $error("channel 1 jumped");

  // pulses only change together with a new output beat
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |=> (out_tvalid || $stable(out_tdata)))
    else $error("pulse changed without an output beat");

endmodule

bind servo_angle_pulse_slew_top sps_chk u_sps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
